[src/fgme_pkg.sv]
// Shared types and constants of the full grid multilinear evaluator.
// No dependencies; used by full_grid_multilinear_eval.
package fgme_pkg;

	localparam int DEFAULT_DIMS      = 2;
	localparam int DEFAULT_MAX_LEVEL = 5;
	localparam int IO_DIMS           = 2;
	localparam int ADDR_W            = 10;
	localparam int STORE_DEPTH       = 1 << ADDR_W;
	localparam int COEF_W            = 32;
	localparam int CFG_INDEX_W       = 3;
	localparam int CFG_DATA_W        = 32;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_DIM0     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_DIM1     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BOX_ENABLE     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_DIM0    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_DIM1    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_WIDTH_DIM0 = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_WIDTH_DIM1 = 3'd6;

	// request kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_EVAL  = 1'b1;

	localparam logic [31:0] INV_WIDTH_RESET = 32'h0001_0000;

	typedef struct packed {
		logic               kind;
		logic [9:0]         coeff_address;
		logic signed [31:0] coeff_value;
		logic signed [31:0] coord_0;
		logic signed [31:0] coord_1;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] interpolated_value;
		logic               saturated;
	} out_item_t;

endpackage

[src/full_grid_multilinear_eval.sv]
// Top level of the full grid multilinear evaluator: config registers,
// nine-stage pipeline and a duplicated coefficient store. Uses fgme_pkg.
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid / in_stall       | in_data  (fgme_pkg::in_item_t)
//  out     | output    | out_valid / out_stall     | out_data (fgme_pkg::out_item_t)
//  cfg     | input     | cfg_we (no wait)          | cfg_index, cfg_data
//
// One request enters per cycle while the pipeline is not stalled. The stage
// chain runs normalize, cell, weights, store read, two multiply stages and the
// final sum with saturation.
// Four corner reads per cycle come from two store copies with two ports each.
// Reset clears valid bits and config registers; payload and store are not cleared.
// A stall on a valid output freezes the whole pipeline, and in_stall follows it.
module full_grid_multilinear_eval #(
	parameter int DIMS      = fgme_pkg::DEFAULT_DIMS,
	parameter int MAX_LEVEL = fgme_pkg::DEFAULT_MAX_LEVEL
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  fgme_pkg::in_item_t                   in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output fgme_pkg::out_item_t                  out_data,
	input  logic                                 cfg_we,
	input  logic [fgme_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [fgme_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import fgme_pkg::*;

	localparam int NDIM   = (DIMS < IO_DIMS) ? DIMS : IO_DIMS;
	localparam int LV_W   = 4;
	localparam int CELL_W = MAX_LEVEL;
	localparam int NC_W   = 58;
	localparam int WT_W   = 24;
	localparam int WP_W   = 30;
	localparam int SUM_W  = 64;
	localparam int ASUM_W = (2 * MAX_LEVEL + 1 > ADDR_W) ? 2 * MAX_LEVEL + 1 : ADDR_W;
	localparam logic signed [NC_W-1:0] ONE_Q16  = NC_W'(65536);
	localparam logic signed [NC_W-1:0] W_LIMIT  = NC_W'(4194304);

	// configuration registers
	logic [2:0]  level_q     [IO_DIMS];
	logic        box_en_q;
	logic [31:0] offset_q    [IO_DIMS];
	logic [31:0] inv_width_q [IO_DIMS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < IO_DIMS; d++) begin
				level_q[d]     <= 3'd1;
				offset_q[d]    <= '0;
				inv_width_q[d] <= INV_WIDTH_RESET;
			end
			box_en_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEVEL_DIM0:     level_q[0]     <= cfg_data[2:0];
				REG_LEVEL_DIM1:     level_q[1]     <= cfg_data[2:0];
				REG_BOX_ENABLE:     box_en_q       <= cfg_data[0];
				REG_OFFSET_DIM0:    offset_q[0]    <= cfg_data;
				REG_OFFSET_DIM1:    offset_q[1]    <= cfg_data;
				REG_INV_WIDTH_DIM0: inv_width_q[0] <= cfg_data;
				REG_INV_WIDTH_DIM1: inv_width_q[1] <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective level, node count and active flag per dimension
	logic [LV_W-1:0]   lv     [IO_DIMS];
	logic [CELL_W-1:0] len    [IO_DIMS];
	logic              used   [IO_DIMS];

	always_comb begin
		for (int d = 0; d < IO_DIMS; d++) begin
			if (level_q[d] == 3'd0)
				lv[d] = LV_W'(1);
			else if ({1'b0, level_q[d]} > LV_W'(MAX_LEVEL))
				lv[d] = LV_W'(MAX_LEVEL);
			else
				lv[d] = {1'b0, level_q[d]};
			len[d]  = CELL_W'((32'd1 << lv[d]) - 32'd1);
			used[d] = (d < NDIM) && (lv[d] != LV_W'(1));
		end
	end

	// pipeline advance
	logic en;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic kind_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6 && (kind_s6 == KIND_EVAL);
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// payload registers
	in_item_t                 item_s1, item_s2, item_s3, item_s4, item_s5;
	logic [ADDR_W-1:0]        waddr_s6;
	logic [COEF_W-1:0]        wdata_s6;
	logic signed [31:0]       coord_s2 [IO_DIMS];
	logic [32:0]              mag_s2   [IO_DIMS];
	logic                     neg_s2   [IO_DIMS];
	logic [63:0]              prod_s3  [IO_DIMS];
	logic signed [NC_W-1:0]   ncoff_s3 [IO_DIMS];
	logic                     neg_s3   [IO_DIMS];
	logic signed [NC_W-1:0]   nc_s4    [IO_DIMS];
	logic signed [NC_W-1:0]   nc_s5    [IO_DIMS];
	logic [CELL_W-1:0]        cell_s5  [IO_DIMS];
	logic signed [WT_W-1:0]   w_s6     [IO_DIMS][2];
	logic [ADDR_W-1:0]        raddr_s6 [4];
	logic                     mask_s6  [4];
	logic signed [WP_W-1:0]   wp_s7    [4];
	logic                     mask_s7  [4];
	logic signed [COEF_W-1:0] coef_s7  [4];
	logic signed [SUM_W-1:0]  term_s8  [4];
	out_item_t                out_s9;

	// stage logic
	logic signed [32:0]     diff_c   [IO_DIMS];
	logic signed [NC_W-1:0] nc_c     [IO_DIMS];
	logic [CELL_W-1:0]      cell_c   [IO_DIMS];
	logic signed [WT_W-1:0] w_c      [IO_DIMS][2];
	logic [CELL_W-1:0]      idx_c    [IO_DIMS][2];
	logic [ADDR_W-1:0]      raddr_c  [4];
	logic                   mask_c   [4];
	logic signed [WP_W-1:0] wp_c     [4];
	logic signed [SUM_W-1:0] sum_c;
	logic signed [SUM_W-17:0] res_c;

	always_comb begin
		logic [4:0]             sh;
		logic [63:0]            rmask, pos, rnd;
		logic signed [NC_W-1:0] t, araw, lenm1, w1, w0;
		logic [ASUM_W-1:0]      asum;
		logic signed [2*WT_W-1:0] wprod;
		for (int d = 0; d < IO_DIMS; d++) begin
			// stage 2: offset difference at full precision
			diff_c[d] = (d == 0) ? 33'(item_s1.coord_0) : 33'(item_s1.coord_1);
			diff_c[d] = diff_c[d] - 33'($signed(offset_q[d]));
			// stage 4: grid units
			sh    = 5'd16 - 5'(lv[d]);
			rmask = (64'd1 << sh) - 64'd1;
			pos   = prod_s3[d] >> sh;
			rnd   = (prod_s3[d] + rmask) >> sh;
			if (!box_en_q)
				nc_c[d] = ncoff_s3[d];
			else if (neg_s3[d])
				nc_c[d] = -$signed(NC_W'(rnd));
			else
				nc_c[d] = $signed(NC_W'(pos));
			// stage 5: cell, clamped to the interior cells
			t     = nc_s4[d] - NC_W'(1);
			araw  = t >>> 16;
			lenm1 = NC_W'(len[d]) - NC_W'(1);
			if (!used[d] || araw < NC_W'(1))
				cell_c[d] = CELL_W'(1);
			else if (araw > lenm1)
				cell_c[d] = CELL_W'(lenm1);
			else
				cell_c[d] = CELL_W'(araw);
			// stage 6: weights, saturated
			w1 = nc_s5[d] - (NC_W'(cell_s5[d]) <<< 16);
			w0 = ONE_Q16 - w1;
			if (!used[d]) begin
				w_c[d][0] = WT_W'(ONE_Q16);
				w_c[d][1] = '0;
			end else begin
				w_c[d][0] = (w0 > W_LIMIT) ? WT_W'(W_LIMIT) :
				            (w0 < -W_LIMIT) ? WT_W'(-W_LIMIT) : WT_W'(w0);
				w_c[d][1] = (w1 > W_LIMIT) ? WT_W'(W_LIMIT) :
				            (w1 < -W_LIMIT) ? WT_W'(-W_LIMIT) : WT_W'(w1);
			end
			idx_c[d][0] = used[d] ? cell_s5[d] - CELL_W'(1) : '0;
			idx_c[d][1] = used[d] ? cell_s5[d] : '0;
		end
		// corner addresses, dimension 1 fastest
		for (int c = 0; c < 4; c++) begin
			if (NDIM == 1)
				asum = ASUM_W'(idx_c[0][c % 2]);
			else
				asum = ASUM_W'(idx_c[0][c % 2]) * ASUM_W'(len[1])
				     + ASUM_W'(idx_c[1][c / 2]);
			raddr_c[c] = asum[ADDR_W-1:0];
			mask_c[c]  = !((c % 2 == 1) && !used[0]) && !((c / 2 == 1) && !used[1]);
			// stage 7: corner weight
			wprod   = (2*WT_W)'(w_s6[0][c % 2]) * (2*WT_W)'(w_s6[1][c / 2]);
			wp_c[c] = WP_W'(wprod >>> 16);
		end
		// stage 9: sum and saturate
		sum_c = term_s8[0] + term_s8[1] + term_s8[2] + term_s8[3];
		res_c = (SUM_W-16)'(sum_c >>> 16);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= in_data;
			item_s2 <= item_s1;
			item_s3 <= item_s2;
			item_s4 <= item_s3;
			item_s5 <= item_s4;
			kind_s6  <= item_s5.kind;
			waddr_s6 <= item_s5.coeff_address;
			wdata_s6 <= item_s5.coeff_value;
			for (int d = 0; d < IO_DIMS; d++) begin
				coord_s2[d] <= (d == 0) ? item_s1.coord_0 : item_s1.coord_1;
				neg_s2[d]   <= diff_c[d][32];
				mag_s2[d]   <= diff_c[d][32] ? 33'(-diff_c[d]) : 33'(diff_c[d]);
				prod_s3[d]  <= 64'(mag_s2[d]) * 64'(inv_width_q[d]);
				neg_s3[d]   <= neg_s2[d];
				ncoff_s3[d] <= NC_W'(coord_s2[d]) <<< lv[d];
				nc_s4[d]    <= nc_c[d];
				nc_s5[d]    <= nc_s4[d];
				cell_s5[d]  <= cell_c[d];
				w_s6[d]     <= w_c[d];
			end
			for (int c = 0; c < 4; c++) begin
				raddr_s6[c] <= raddr_c[c];
				mask_s6[c]  <= mask_c[c];
				wp_s7[c]    <= wp_c[c];
				mask_s7[c]  <= mask_s6[c];
				term_s8[c]  <= mask_s7[c] ? SUM_W'(wp_s7[c]) * SUM_W'(coef_s7[c]) : '0;
			end
			out_s9.saturated <= (res_c > (SUM_W-16)'(32'sh7FFF_FFFF)) ||
			                    (res_c < -(SUM_W-16)'(33'sh0_8000_0000));
			if (res_c > (SUM_W-16)'(32'sh7FFF_FFFF))
				out_s9.interpolated_value <= 32'sh7FFF_FFFF;
			else if (res_c < -(SUM_W-16)'(33'sh0_8000_0000))
				out_s9.interpolated_value <= 32'sh8000_0000;
			else
				out_s9.interpolated_value <= 32'(res_c);
		end
	end

	// coefficient store: two copies, two read ports each
	logic [COEF_W-1:0] mem_a [STORE_DEPTH];
	logic [COEF_W-1:0] mem_b [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s6 && kind_s6 == KIND_WRITE) begin
				mem_a[waddr_s6] <= wdata_s6;
				mem_b[waddr_s6] <= wdata_s6;
			end
			coef_s7[0] <= mem_a[raddr_s6[0]];
			coef_s7[1] <= mem_a[raddr_s6[1]];
			coef_s7[2] <= mem_b[raddr_s6[2]];
			coef_s7[3] <= mem_b[raddr_s6[3]];
		end
	end

	assign out_valid = v_s9;
	assign out_data  = out_s9;

endmodule
